// ===== hw/rtl/xbh_pkg.sv =====
// xbh_pkg: types and constants shared by the xorshift block hash modules
// holds the request and result records, the seed reset values and the mixer shifts
// depends on nothing
`default_nettype none

package xbh_pkg;

    localparam logic [5:0] BlockBytes = 6'd32;

    localparam logic [63:0] SeedLowReset  = 64'h5555_5555_5555_5555;
    localparam logic [63:0] SeedHighReset = 64'haaaa_aaaa_aaaa_aaaa;

    localparam int unsigned ShiftByte   = 30;
    localparam int unsigned ShiftFirst  = 23;
    localparam int unsigned ShiftT      = 18;
    localparam int unsigned ShiftSecond = 5;

    typedef enum logic
    {
        REG_SEED_LOW  = 1'b0,
        REG_SEED_HIGH = 1'b1
    } cfg_reg_t;

    typedef struct packed
    {
        logic [7:0] data_byte;
        logic       has_byte;
        logic       end_of_message;
    } cmd_t;

    typedef struct packed
    {
        logic [63:0] hash_word;
        logic [1:0]  word_index;
        logic        last_word;
    } result_t;

endpackage

`default_nettype wire

// ===== hw/rtl/xbh_front.sv =====
// xbh_front: input side of the block hash, a two-entry request queue
// drops idle requests and hands the rest to the engine; uses xbh_pkg
`default_nettype none

module xbh_front
(
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          push,
    output logic               full,
    input  wire xbh_pkg::cmd_t in_cmd,
    output logic               cmd_valid,
    output xbh_pkg::cmd_t      cmd,
    input  wire logic          cmd_pop
);

    xbh_pkg::cmd_t mem_reg [2];
    logic          wr_ptr_reg;
    logic          rd_ptr_reg;
    logic [1:0]    count_reg;
    logic [1:0]    count_next;
    logic          accept;
    logic          keep;
    logic          write;
    logic          read;

    assign full      = (count_reg == 2'd2);
    assign accept    = push && !full;
    // an item with neither byte nor end changes nothing
    assign keep      = in_cmd.has_byte || in_cmd.end_of_message;
    assign write     = accept && keep;
    assign cmd_valid = (count_reg != 2'd0);
    assign read      = cmd_pop && cmd_valid;
    assign cmd       = mem_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (write && !read)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (read && !write)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            count_reg <= count_next;
            if (write)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (read)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (write)
        begin
            mem_reg[wr_ptr_reg] <= in_cmd;
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/xbh_engine.sv =====
// xbh_engine: back side of the block hash, block buffer, mixer and accumulators
// runs 128 mixer steps per block and emits the four hash words; uses xbh_pkg
`default_nettype none

module xbh_engine
(
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic [63:0]   seed_low,
    input  wire logic [63:0]   seed_high,
    input  wire logic          cmd_valid,
    input  wire xbh_pkg::cmd_t cmd,
    output logic               cmd_pop,
    output logic               res_push,
    output xbh_pkg::result_t   res,
    input  wire logic          res_full
);

    typedef enum logic [1:0]
    {
        ST_IDLE,
        ST_HASH,
        ST_EMIT
    } state_t;

    state_t      state_reg;
    logic        open_reg;
    logic        final_reg;
    logic [5:0]  count_reg;
    logic [6:0]  step_reg;
    logic [1:0]  widx_reg;

    logic [63:0] first_reg;
    logic [63:0] second_reg;
    logic [63:0] acc_reg [4];
    logic [63:0] pass_acc_reg;
    logic [7:0]  buf_reg [32];

    logic        init;
    logic        full_hash;
    logic        store;
    logic        hashing;
    logic        last_step;
    logic        pass_end;
    logic [2:0]  pass_num;
    logic [1:0]  sub_sel;
    logic [2:0]  byte_sel;
    logic [4:0]  addr;
    logic [7:0]  byte_val;
    logic [63:0] sum;
    logic [63:0] pass_in;
    logic [63:0] pass_x;
    logic [63:0] t_val;
    logic [63:0] first_next;
    logic [63:0] second_next;

    assign init      = (state_reg == ST_IDLE) && cmd_valid && !open_reg;
    assign full_hash = (state_reg == ST_IDLE) && cmd_valid && open_reg && cmd.has_byte
                       && (count_reg == xbh_pkg::BlockBytes);
    assign cmd_pop   = (state_reg == ST_IDLE) && cmd_valid && open_reg && !full_hash;
    assign store     = cmd_pop && cmd.has_byte;
    assign hashing   = (state_reg == ST_HASH);
    assign last_step = (step_reg == 7'd127);
    assign pass_end  = (step_reg[3:0] == 4'd15);

    // passes visit sub-blocks 0,1,2,3,3,2,1,0; each pass goes forward then back
    assign pass_num = step_reg[6:4];
    assign sub_sel  = pass_num[2] ? ~pass_num[1:0] : pass_num[1:0];
    assign byte_sel = step_reg[3] ? ~step_reg[2:0] : step_reg[2:0];
    assign addr     = {sub_sel, byte_sel};
    // positions past the byte count read as zero padding
    assign byte_val = ({1'b0, addr} < count_reg) ? buf_reg[addr] : 8'd0;

    assign sum         = first_reg + second_reg;
    assign pass_in     = (step_reg[3:0] == 4'd0) ? 64'd0 : pass_acc_reg;
    assign pass_x      = pass_in ^ sum;
    assign first_next  = second_reg ^ (64'(byte_val) << xbh_pkg::ShiftByte);
    assign t_val       = first_reg ^ (first_reg << xbh_pkg::ShiftFirst);
    assign second_next = t_val ^ second_reg ^ (t_val >> xbh_pkg::ShiftT)
                         ^ (second_reg >> xbh_pkg::ShiftSecond);

    assign res_push       = (state_reg == ST_EMIT) && !res_full;
    assign res.hash_word  = acc_reg[widx_reg];
    assign res.word_index = widx_reg;
    assign res.last_word  = (widx_reg == 2'd0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            open_reg  <= 1'b0;
            final_reg <= 1'b0;
            count_reg <= 6'd0;
            step_reg  <= 7'd0;
            widx_reg  <= 2'd0;
        end
        else
        begin
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (init)
                    begin
                        open_reg  <= 1'b1;
                        count_reg <= 6'd0;
                    end
                    else if (full_hash)
                    begin
                        // block is full and another byte waits: hash first, then retry
                        state_reg <= ST_HASH;
                        final_reg <= 1'b0;
                    end
                    else if (cmd_pop)
                    begin
                        if (cmd.has_byte)
                        begin
                            count_reg <= count_reg + 6'd1;
                        end
                        if (cmd.end_of_message)
                        begin
                            state_reg <= ST_HASH;
                            final_reg <= 1'b1;
                        end
                    end
                end
                ST_HASH:
                begin
                    step_reg <= step_reg + 7'd1;
                    if (last_step)
                    begin
                        count_reg <= 6'd0;
                        if (final_reg)
                        begin
                            state_reg <= ST_EMIT;
                            widx_reg  <= 2'd3;
                            open_reg  <= 1'b0;
                        end
                        else
                        begin
                            state_reg <= ST_IDLE;
                        end
                    end
                end
                ST_EMIT:
                begin
                    if (res_push)
                    begin
                        widx_reg <= widx_reg - 2'd1;
                        if (widx_reg == 2'd0)
                        begin
                            state_reg <= ST_IDLE;
                        end
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (init)
        begin
            first_reg  <= seed_low;
            second_reg <= seed_high;
            for (int k = 0; k < 4; k++)
            begin
                acc_reg[2'(k)] <= 64'd0;
            end
        end
        else if (hashing)
        begin
            first_reg    <= first_next;
            second_reg   <= second_next;
            pass_acc_reg <= pass_x;
            if (pass_end)
            begin
                acc_reg[pass_num[1:0]] <= acc_reg[pass_num[1:0]] ^ pass_x;
            end
        end
        if (store)
        begin
            buf_reg[count_reg[4:0]] <= cmd.data_byte;
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/xbh_rqueue.sv =====
// xbh_rqueue: two-entry result queue in front of the result ports
// decouples the engine from a stalling receiver; uses xbh_pkg
`default_nettype none

module xbh_rqueue
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             res_push,
    input  wire xbh_pkg::result_t res,
    output logic                  res_full,
    output logic                  empty,
    input  wire logic             pop,
    output xbh_pkg::result_t      head
);

    xbh_pkg::result_t mem_reg [2];
    logic             wr_ptr_reg;
    logic             rd_ptr_reg;
    logic [1:0]       count_reg;
    logic [1:0]       count_next;
    logic             write;
    logic             read;

    assign res_full = (count_reg == 2'd2);
    assign empty    = (count_reg == 2'd0);
    assign write    = res_push && !res_full;
    assign read     = pop && !empty;
    assign head     = mem_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (write && !read)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (read && !write)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            count_reg <= count_next;
            if (write)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (read)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (write)
        begin
            mem_reg[wr_ptr_reg] <= res;
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/xorshift_block_hash_256.sv =====
// xorshift_block_hash_256: top level of the 256-bit xorshift block hash
// holds the seed registers and joins xbh_front, xbh_engine and xbh_rqueue; uses xbh_pkg
//
// usage: message bytes go in through a queue-like port (push/full) with has_byte and
// end_of_message; an item with neither flag is taken and dropped. after the final item
// of a message four results come out through empty/pop: hash words for index 3,2,1,0,
// last_word set on index 0. seed_low (index 0) and seed_high (index 1) are written on
// the cfg port, which is always ready, and are loaded into the mixer at message start.
// processing: each byte request is stored while the engine is idle; every 32-byte block
// takes 128 steps on the single mixer step unit, one step a cycle, and the waiting byte
// is then retried. the final block is hashed after the end request, and the four hash
// words are emitted once it is done.
// the input queue holds two requests and the result queue two words; a stalled
// receiver holds the engine in its emit phase, and the input queue then fills.
// reset: seeds return to their defaults, queues empty, no message open.
`default_nettype none

module xorshift_block_hash_256
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        push,
    output logic             full,
    input  wire logic [7:0]  data_byte,
    input  wire logic        has_byte,
    input  wire logic        end_of_message,
    output logic             empty,
    input  wire logic        pop,
    output logic [63:0]      hash_word,
    output logic [1:0]       word_index,
    output logic             last_word,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic        cfg_index,
    input  wire logic [63:0] cfg_data
);

    logic [63:0]      seed_low_reg;
    logic [63:0]      seed_high_reg;
    xbh_pkg::cmd_t    in_cmd;
    xbh_pkg::cmd_t    cmd;
    logic             cmd_valid;
    logic             cmd_pop;
    xbh_pkg::result_t res;
    xbh_pkg::result_t head;
    logic             res_push;
    logic             res_full;

    assign cfg_ready = 1'b1;

    assign in_cmd.data_byte      = data_byte;
    assign in_cmd.has_byte       = has_byte;
    assign in_cmd.end_of_message = end_of_message;

    assign hash_word  = head.hash_word;
    assign word_index = head.word_index;
    assign last_word  = head.last_word;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seed_low_reg  <= xbh_pkg::SeedLowReset;
            seed_high_reg <= xbh_pkg::SeedHighReset;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (xbh_pkg::cfg_reg_t'(cfg_index))
                xbh_pkg::REG_SEED_LOW:  seed_low_reg  <= cfg_data;
                xbh_pkg::REG_SEED_HIGH: seed_high_reg <= cfg_data;
                default:                seed_low_reg  <= seed_low_reg;
            endcase
        end
    end

    xbh_front u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .in_cmd    (in_cmd),
        .cmd_valid (cmd_valid),
        .cmd       (cmd),
        .cmd_pop   (cmd_pop)
    );

    xbh_engine u_engine
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .seed_low  (seed_low_reg),
        .seed_high (seed_high_reg),
        .cmd_valid (cmd_valid),
        .cmd       (cmd),
        .cmd_pop   (cmd_pop),
        .res_push  (res_push),
        .res       (res),
        .res_full  (res_full)
    );

    xbh_rqueue u_rqueue
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .res_push (res_push),
        .res      (res),
        .res_full (res_full),
        .empty    (empty),
        .pop      (pop),
        .head     (head)
    );

endmodule

`default_nettype wire
